@@ design/jetp_pkg.sv @@
// ----------------------------------------------------------------------------
// jetp_pkg
// Types, constants and helpers for the Julia escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package jetp_pkg;

   localparam int DEFAULT_FRACTION_BITS = 28;

   localparam int COORD_BITS = 10;
   localparam int COUNT_BITS = 16;
   localparam int WORD_BITS  = 32;
   localparam int STEP_BITS  = 31;
   localparam int PROD_BITS  = 64;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ITERATION_LIMIT = 3'd0,
      CSR_PIXEL_STEP      = 3'd1,
      CSR_REAL_OFFSET     = 3'd2,
      CSR_IMAG_OFFSET     = 3'd3,
      CSR_CONST_REAL      = 3'd4,
      CSR_CONST_IMAG      = 3'd5,
      CSR_BASE_COLOUR     = 3'd6,
      CSR_COLOUR_MASK     = 3'd7
   } csr_index_type;

   localparam logic [COUNT_BITS-1:0]       RST_ITERATION_LIMIT = 16'd100;
   localparam logic [STEP_BITS-1:0]        RST_PIXEL_STEP      = 31'd894785;
   localparam logic signed [WORD_BITS-1:0] RST_REAL_OFFSET     = -32'sd402653184;
   localparam logic signed [WORD_BITS-1:0] RST_IMAG_OFFSET     = -32'sd375809638;
   localparam logic signed [WORD_BITS-1:0] RST_CONST_REAL      = -32'sd134217728;
   localparam logic signed [WORD_BITS-1:0] RST_CONST_IMAG      = 32'sd134217728;
   localparam logic [WORD_BITS-1:0]        RST_BASE_COLOUR     = 32'd16777215;
   localparam logic [WORD_BITS-1:0]        RST_COLOUR_MASK     = 32'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_X,
      ST_MAP_Y,
      ST_LOAD_I,
      ST_SQ_R,
      ST_SQ_I,
      ST_CROSS,
      ST_UPDATE,
      ST_COLOUR,
      ST_FINISH
   } jetp_state_type;

   function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [PROD_BITS-1:0] v);
      logic signed [PROD_BITS-1:0] hi;
      logic signed [PROD_BITS-1:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORD_BITS-1:0];
      end else begin
         return v[WORD_BITS-1:0];
      end
   endfunction

endpackage

@@ design/jetp_if.sv @@
// ----------------------------------------------------------------------------
// jetp_if
// Valid/ready channels carrying pixel requests and pixel results.
// ----------------------------------------------------------------------------
interface jetp_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] pixel_x;
   logic [9:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jetp_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  out_x;
   logic [9:0]  out_y;
   logic [31:0] pixel_colour;
   logic [15:0] iteration_count;

   modport source (output valid, output out_x, output out_y, output pixel_colour,
                   output iteration_count, input ready);
   modport sink   (input valid, input out_x, input out_y, input pixel_colour,
                   input iteration_count, output ready);
endinterface

@@ design/julia_escape_time_pixel.sv @@
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Escape-time Julia set evaluator for one pixel per item, Q4.28 fixed point.
// ----------------------------------------------------------------------------
// One item at a time: the next item is accepted only once the previous result
// has been placed in the output register. A single 32x32 signed multiplier
// serves a small sequencer three times per iteration (zr*zr, zi*zi, zr*zi),
// followed by an update step; mapping and colouring reuse it.
// The result sits in an output register, so a stalled result consumer only
// holds the block once the next result is ready.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel #(
   parameter int FRACTION_BITS = jetp_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   jetp_req_if.sink                            req_item,
   jetp_rsp_if.source                          rsp_item,
   input  logic                                csr_wr_en,
   input  logic [jetp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jetp_pkg::WORD_BITS-1:0]      csr_wr_data
);
   import jetp_pkg::*;

   localparam logic [PROD_BITS-1:0] ESCAPE_BOUND = 64'd1 << (2 * FRACTION_BITS + 2);

   jetp_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]       limit_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic signed [WORD_BITS-1:0] roff_ff;
   logic signed [WORD_BITS-1:0] ioff_ff;
   logic signed [WORD_BITS-1:0] cr_ff;
   logic signed [WORD_BITS-1:0] ci_ff;
   logic [WORD_BITS-1:0]        base_ff;
   logic [WORD_BITS-1:0]        mask_ff;

   logic [COORD_BITS-1:0]       px_ff, px_in;
   logic [COORD_BITS-1:0]       py_ff, py_in;
   logic signed [WORD_BITS-1:0] zr_ff, zr_in;
   logic signed [WORD_BITS-1:0] zi_ff, zi_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [PROD_BITS-1:0] rr_ff, rr_in;
   logic signed [PROD_BITS-1:0] diff_ff, diff_in;
   logic                        esc_ff, esc_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]       rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]       rsp_y_ff, rsp_y_in;
   logic [WORD_BITS-1:0]        rsp_colour_ff, rsp_colour_in;
   logic [COUNT_BITS-1:0]       rsp_count_ff, rsp_count_in;

   logic signed [WORD_BITS-1:0] op_a;
   logic signed [WORD_BITS-1:0] op_b;
   logic [PROD_BITS-1:0]        mag_sum;
   logic signed [PROD_BITS-1:0] re_full;
   logic signed [PROD_BITS-1:0] im_full;
   logic                        req_fire;
   logic                        rsp_free;

   assign req_fire = req_item.valid && req_item.ready;
   assign rsp_free = !rsp_valid_ff || rsp_item.ready;

   assign req_item.ready           = (state_ff == ST_IDLE);
   assign rsp_item.valid           = rsp_valid_ff;
   assign rsp_item.out_x           = rsp_x_ff;
   assign rsp_item.out_y           = rsp_y_ff;
   assign rsp_item.pixel_colour    = rsp_colour_ff;
   assign rsp_item.iteration_count = rsp_count_ff;

   assign mag_sum = unsigned'(rr_ff) + unsigned'(prod_ff);
   assign re_full = (diff_ff >>> FRACTION_BITS) + PROD_BITS'(cr_ff);
   assign im_full = (prod_ff >>> (FRACTION_BITS - 1)) + PROD_BITS'(ci_ff);

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      count_in      = count_ff;
      rr_in         = rr_ff;
      diff_in       = diff_ff;
      esc_in        = esc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_item.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_count_in  = rsp_count_ff;
      op_a          = zr_ff;
      op_b          = zr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               px_in    = req_item.pixel_x;
               py_in    = req_item.pixel_y;
               count_in = '0;
               state_in = ST_MAP_X;
            end
         end
         ST_MAP_X: begin
            op_a     = signed'({{(WORD_BITS-COORD_BITS){1'b0}}, px_ff});
            op_b     = signed'({1'b0, step_ff});
            state_in = ST_MAP_Y;
         end
         ST_MAP_Y: begin
            op_a     = signed'({{(WORD_BITS-COORD_BITS){1'b0}}, py_ff});
            op_b     = signed'({1'b0, step_ff});
            zr_in    = sat32(prod_ff + PROD_BITS'(roff_ff));
            state_in = ST_LOAD_I;
         end
         ST_LOAD_I: begin
            zi_in    = sat32(prod_ff + PROD_BITS'(ioff_ff));
            state_in = ST_SQ_I;
         end
         ST_SQ_R: begin
            state_in = ST_SQ_I;
         end
         ST_SQ_I: begin
            op_a     = zi_ff;
            op_b     = zi_ff;
            rr_in    = prod_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            op_a     = zr_ff;
            op_b     = zi_ff;
            diff_in  = rr_ff - prod_ff;
            esc_in   = (mag_sum >= ESCAPE_BOUND);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!esc_ff && (count_ff < limit_ff)) begin
               zr_in    = sat32(re_full);
               zi_in    = sat32(im_full);
               count_in = count_ff + 1'b1;
               state_in = ST_SQ_R;
            end else begin
               state_in = ST_COLOUR;
            end
         end
         ST_COLOUR: begin
            op_a     = signed'(~mask_ff);
            op_b     = signed'({{(WORD_BITS-COUNT_BITS){1'b0}}, count_ff});
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            op_a = signed'(~mask_ff);
            op_b = signed'({{(WORD_BITS-COUNT_BITS){1'b0}}, count_ff});
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = px_ff;
               rsp_y_in      = py_ff;
               rsp_count_in  = count_ff;
               rsp_colour_in = (count_ff == limit_ff) ? '0
                                                      : (base_ff & prod_ff[WORD_BITS-1:0]);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= RST_ITERATION_LIMIT;
         step_ff      <= RST_PIXEL_STEP;
         roff_ff      <= RST_REAL_OFFSET;
         ioff_ff      <= RST_IMAG_OFFSET;
         cr_ff        <= RST_CONST_REAL;
         ci_ff        <= RST_CONST_IMAG;
         base_ff      <= RST_BASE_COLOUR;
         mask_ff      <= RST_COLOUR_MASK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ITERATION_LIMIT: limit_ff <= csr_wr_data[COUNT_BITS-1:0];
               CSR_PIXEL_STEP:      step_ff  <= csr_wr_data[STEP_BITS-1:0];
               CSR_REAL_OFFSET:     roff_ff  <= signed'(csr_wr_data);
               CSR_IMAG_OFFSET:     ioff_ff  <= signed'(csr_wr_data);
               CSR_CONST_REAL:      cr_ff    <= signed'(csr_wr_data);
               CSR_CONST_IMAG:      ci_ff    <= signed'(csr_wr_data);
               CSR_BASE_COLOUR:     base_ff  <= csr_wr_data;
               CSR_COLOUR_MASK:     mask_ff  <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      count_ff      <= count_in;
      prod_ff       <= prod_in;
      rr_ff         <= rr_in;
      diff_ff       <= diff_in;
      esc_ff        <= esc_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
